/* sv/fcu_pkg.sv */
// ----------------------------------------------------------------------------
// fcu_pkg
// shared widths, register map and control types of the fir convolution unit
// ----------------------------------------------------------------------------
package fcu_pkg;

    localparam int VALUE_W          = 16;
    localparam int INDEX_W          = 6;
    localparam int TAP_COUNT_W      = 7;
    localparam int PRODUCT_W        = 32;
    localparam int ACC_W            = 40;
    localparam int DEFAULT_MAX_TAPS = 64;
    localparam int TAP_COUNT_RESET  = 64;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-3:0] REG_TAP_COUNT = 1'b0;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

/* sv/fcu_mac.sv */
// ----------------------------------------------------------------------------
// fcu_mac
// shared multiply-accumulate: registered product, 40-bit accumulator
// ----------------------------------------------------------------------------
module fcu_mac
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fcu_pkg::mac_ctrl_t                      ctrl,
    input  logic signed [fcu_pkg::VALUE_W-1:0]      sample,
    input  logic signed [fcu_pkg::VALUE_W-1:0]      coeff,
    output logic signed [fcu_pkg::ACC_W-1:0]        acc,
    output logic                                    busy
);

    logic signed [fcu_pkg::PRODUCT_W-1:0] prod_reg;
    logic                                 prod_valid_reg;
    logic signed [fcu_pkg::ACC_W-1:0]     acc_reg;
    logic signed [fcu_pkg::ACC_W-1:0]     prod_ext;

    assign prod_ext = {{(fcu_pkg::ACC_W - fcu_pkg::PRODUCT_W){prod_reg[fcu_pkg::PRODUCT_W-1]}},
                       prod_reg};

    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coeff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_valid_reg;

endmodule

/* sv/fir_full_convolution_unit.sv */
// ----------------------------------------------------------------------------
// fir_full_convolution_unit
// streaming fir filter giving the full linear convolution of a sample frame
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one Q1.14 coefficient; the unit stays idle.
// A sample item (mode 1) is pushed into a circular sample history and one
// shared multiply-accumulate walks the taps in use, one tap per cycle; the
// result may then wait on the output side. A sample with frame_end also
// flushes zero samples, one fewer than the taps in use; the history is then
// cleared at once through its fill count. in_ready is low while an item is
// at work. Results are exact 40-bit sums with 27 fractional bits; the last
// result of a frame carries result_last. tap_count lies at APB address 0.
// ----------------------------------------------------------------------------
module fir_full_convolution_unit
#(
    parameter int MAX_TAPS = fcu_pkg::DEFAULT_MAX_TAPS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [fcu_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [fcu_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [fcu_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    mode,
    input  logic [fcu_pkg::INDEX_W-1:0]             coeff_index,
    input  logic signed [fcu_pkg::VALUE_W-1:0]      value,
    input  logic                                    frame_end,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [fcu_pkg::ACC_W-1:0]        result,
    output logic                                    result_last
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FW = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [fcu_pkg::TAP_COUNT_W-1:0]     tap_count_reg;

    logic signed [fcu_pkg::VALUE_W-1:0]  coeff_mem [MAX_TAPS];
    logic signed [fcu_pkg::VALUE_W-1:0]  hist_mem  [MAX_TAPS];

    logic [AW-1:0]                       wptr_reg;
    logic [AW-1:0]                       wptr_next;
    logic [AW-1:0]                       rptr_reg;
    logic [FW-1:0]                       fill_reg;
    logic [FW-1:0]                       k_reg;
    logic [FW-1:0]                       tail_left_reg;
    logic                                frame_reg;
    logic [FW-1:0]                       taps;

    logic signed [fcu_pkg::VALUE_W-1:0]  hist_rd_reg;
    logic signed [fcu_pkg::VALUE_W-1:0]  coeff_rd_reg;
    logic                                rd_valid_reg;
    logic                                live_reg;

    logic signed [fcu_pkg::ACC_W-1:0]    result_reg;
    logic                                result_last_reg;
    logic                                out_valid_reg;

    logic                                cfg_write;
    logic                                in_take;
    logic                                coeff_write;
    logic                                push_en;
    logic signed [fcu_pkg::VALUE_W-1:0]  push_data;
    logic                                emit;
    logic                                issue_last;
    logic                                mac_busy;
    logic signed [fcu_pkg::ACC_W-1:0]    mac_acc;
    fcu_pkg::mac_ctrl_t                  mac_ctrl;
    logic signed [fcu_pkg::VALUE_W-1:0]  mac_sample;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[fcu_pkg::APB_ADDR_W-1:2] == fcu_pkg::REG_TAP_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[fcu_pkg::APB_ADDR_W-1:2] == fcu_pkg::REG_TAP_COUNT)
        begin
            prdata = fcu_pkg::APB_DATA_W'(tap_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fcu_pkg::TAP_COUNT_W'(fcu_pkg::TAP_COUNT_RESET);
        end
        else if (cfg_write)
        begin
            tap_count_reg <= pwdata[fcu_pkg::TAP_COUNT_W-1:0];
        end
    end

    // taps in use, clamped to 1..MAX_TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = FW'(1);
        end
        else if (32'(tap_count_reg) > 32'(MAX_TAPS))
        begin
            taps = FW'(MAX_TAPS);
        end
        else
        begin
            taps = FW'(tap_count_reg);
        end
    end

    // control
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_take     = in_valid && in_ready;
    assign coeff_write = in_take && (mode == fcu_pkg::MODE_LOAD)
                         && (32'(coeff_index) < 32'(MAX_TAPS));
    assign emit        = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign issue_last  = (k_reg + FW'(1)) == taps;

    always_comb
    begin
        push_en   = 1'b0;
        push_data = value;
        if (in_take && (mode == fcu_pkg::MODE_SAMPLE))
        begin
            push_en = 1'b1;
        end
        else if (emit && (tail_left_reg != '0))
        begin
            push_en   = 1'b1;
            push_data = '0;
        end
    end

    assign wptr_next = (wptr_reg == AW'(MAX_TAPS - 1)) ? '0 : wptr_reg + AW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (push_en)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    state_next = push_en ? ST_MAC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            tail_left_reg <= '0;
            frame_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            live_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_MAC);
            live_reg     <= k_reg < fill_reg;
            if (in_take && (mode == fcu_pkg::MODE_SAMPLE))
            begin
                frame_reg     <= frame_end;
                tail_left_reg <= frame_end ? taps - FW'(1) : '0;
            end
            else if (emit && (tail_left_reg != '0))
            begin
                tail_left_reg <= tail_left_reg - FW'(1);
            end
            if (push_en)
            begin
                wptr_reg <= wptr_next;
                rptr_reg <= wptr_next;
                k_reg    <= '0;
                if (fill_reg != FW'(MAX_TAPS))
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            else if (state_reg == ST_MAC)
            begin
                k_reg    <= k_reg + FW'(1);
                rptr_reg <= (rptr_reg == '0) ? AW'(MAX_TAPS - 1) : rptr_reg - AW'(1);
            end
            else if (emit && frame_reg && (tail_left_reg == '0))
            begin
                fill_reg <= '0;
            end
        end
    end

    // coefficient store and sample history
    always_ff @(posedge clk)
    begin
        if (coeff_write)
        begin
            coeff_mem[AW'(coeff_index)] <= value;
        end
        coeff_rd_reg <= coeff_mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            hist_mem[wptr_next] <= push_data;
        end
        hist_rd_reg <= hist_mem[rptr_reg];
    end

    // shared multiply-accumulate
    assign mac_ctrl.clear = push_en;
    assign mac_ctrl.valid = rd_valid_reg;
    assign mac_sample     = live_reg ? hist_rd_reg : '0;

    fcu_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .coeff  (coeff_rd_reg),
        .acc    (mac_acc),
        .busy   (mac_busy)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg      <= mac_acc;
            result_last_reg <= frame_reg && (tail_left_reg == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign result      = result_reg;
    assign result_last = result_last_reg;

endmodule
